@@ rtl/qsu_pkg.sv @@
// shared types and constants for the quoted string unescaper
// no dependencies
package qsu_pkg;

  localparam int unsigned CharW  = 8;
  localparam int unsigned CountW = 12;

  // longest text whose bytes are counted before the count saturates
  localparam int unsigned MaxText   = 4095;
  localparam int unsigned FieldCap  = (1 << CountW) - 1;
  localparam int unsigned CountCapI = (MaxText < FieldCap) ? MaxText : FieldCap;
  localparam logic [CountW-1:0] CountCap = CountW'(CountCapI);

  localparam logic [CharW-1:0] ChNul    = 8'h00;
  localparam logic [CharW-1:0] ChQuote  = 8'h22;
  localparam logic [CharW-1:0] ChBslash = 8'h5C;
  localparam logic [CharW-1:0] ChN      = 8'h6E;
  localparam logic [CharW-1:0] ChT      = 8'h74;
  localparam logic [CharW-1:0] ChNl     = 8'h0A;
  localparam logic [CharW-1:0] ChTab    = 8'h09;

  typedef enum logic [2:0] {
    PhExpect = 3'b001,
    PhInside = 3'b010,
    PhEscape = 3'b100
  } phase_e;

  typedef enum logic [1:0] {
    StRun    = 2'd0,
    StClosed = 2'd1,
    StUnterm = 2'd2,
    StReject = 2'd3
  } status_e;

  typedef struct packed {
    logic [CharW-1:0]  out_char;
    logic              char_valid;
    status_e           status;
    logic [CountW-1:0] count;
  } result_t;

endpackage

@@ rtl/qsu_step.sv @@
// parse phase and byte count registers with the per-byte decode
// depends on qsu_pkg
module qsu_step (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic [qsu_pkg::CharW-1:0] char_i,
  output qsu_pkg::result_t          res_o
);

  qsu_pkg::phase_e              phase_q, phase_d;
  logic [qsu_pkg::CountW-1:0]   count_q, count_d;
  logic [qsu_pkg::CountW-1:0]   count_inc;
  logic [qsu_pkg::CountW-1:0]   cnt;
  logic [qsu_pkg::CharW-1:0]    ch;
  logic                         vld;
  qsu_pkg::status_e             status;
  qsu_pkg::phase_e              phase_nx;

  // saturating bump
  assign count_inc = (count_q < qsu_pkg::CountCap) ? count_q + 1'b1 : count_q;

  always_comb begin
    ch       = qsu_pkg::ChNul;
    vld      = 1'b0;
    status   = qsu_pkg::StRun;
    cnt      = count_q;
    phase_nx = phase_q;
    unique case (phase_q)
      qsu_pkg::PhInside: begin
        if (char_i == qsu_pkg::ChNul) begin
          status = qsu_pkg::StUnterm;
        end else if (char_i == qsu_pkg::ChQuote) begin
          cnt    = count_inc;
          status = qsu_pkg::StClosed;
        end else if (char_i == qsu_pkg::ChBslash) begin
          cnt      = count_inc;
          phase_nx = qsu_pkg::PhEscape;
        end else begin
          cnt = count_inc;
          ch  = char_i;
          vld = 1'b1;
        end
      end
      qsu_pkg::PhEscape: begin
        vld = 1'b1;
        if (char_i == qsu_pkg::ChNul) begin
          // dangling backslash at end of text is kept as is
          ch     = qsu_pkg::ChBslash;
          status = qsu_pkg::StUnterm;
        end else begin
          cnt      = count_inc;
          phase_nx = qsu_pkg::PhInside;
          if (char_i == qsu_pkg::ChN) begin
            ch = qsu_pkg::ChNl;
          end else if (char_i == qsu_pkg::ChT) begin
            ch = qsu_pkg::ChTab;
          end else begin
            ch = char_i;
          end
        end
      end
      default: begin
        if (char_i == qsu_pkg::ChQuote) begin
          cnt      = qsu_pkg::CountW'(1);
          phase_nx = qsu_pkg::PhInside;
        end else begin
          cnt    = '0;
          status = qsu_pkg::StReject;
        end
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    count_d = count_q;
    if (en_i) begin
      if (status != qsu_pkg::StRun) begin
        phase_d = qsu_pkg::PhExpect;
        count_d = '0;
      end else begin
        phase_d = phase_nx;
        count_d = cnt;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= qsu_pkg::PhExpect;
      count_q <= '0;
    end else begin
      phase_q <= phase_d;
      count_q <= count_d;
    end
  end

  assign res_o.out_char   = ch;
  assign res_o.char_valid = vld;
  assign res_o.status     = status;
  assign res_o.count      = cnt;

endmodule

@@ rtl/quoted_string_unescaper.sv @@
// top level of the quoted string unescaper: input register, decode, result register
// depends on qsu_pkg and qsu_step
//
// usage
//   input channel: char_in_i with in_valid_i / in_stall_o, one text byte per beat,
//   byte 0 ends the text. output channel: one result beat per input beat on
//   out_char_o, char_valid_o, parse_status_o, consumed_count_o with
//   out_valid_o / out_stall_i.
//   the first byte of a parse must be a double quote, otherwise the beat comes
//   back as rejected with count 0. a closed, unterminated or rejected status
//   ends the parse and the next byte starts a new one.
//   a beat accepted into the input register passes through the decode into the
//   result register, from which it shows on the output.
//   throughput: one beat per cycle while the receiver does not stall, set by the
//   single decode step between the input register and the result register; the parse
//   state updates as a beat moves into the result register.
//   when the receiver stalls, the result register holds; the input register
//   still takes one more beat, then in_stall_o rises until the result drains.
//   reset empties both registers and returns the parse to expecting a quote.
module quoted_string_unescaper (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [qsu_pkg::CharW-1:0]  char_in_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  output logic [qsu_pkg::CharW-1:0]  out_char_o,
  output logic                       char_valid_o,
  output logic [1:0]                 parse_status_o,
  output logic [qsu_pkg::CountW-1:0] consumed_count_o,
  output logic                       out_valid_o,
  input  logic                       out_stall_i
);

  logic                      in_vld_q, in_vld_d;
  logic [qsu_pkg::CharW-1:0] in_char_q;
  logic                      out_vld_q, out_vld_d;
  qsu_pkg::result_t          out_res_q;
  qsu_pkg::result_t          step_res;
  logic                      in_acc;
  logic                      adv;
  logic                      out_blocked;

  assign out_blocked = out_vld_q && out_stall_i;
  assign adv         = in_vld_q && !out_blocked;
  assign in_stall_o  = in_vld_q && out_blocked;
  assign in_acc      = in_valid_i && !in_stall_o;

  qsu_step u_step (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (adv),
    .char_i (in_char_q),
    .res_o  (step_res)
  );

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_acc) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
    out_vld_d = out_vld_q;
    if (adv) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_char_q <= char_in_i;
    end
    if (adv) begin
      out_res_q <= step_res;
    end
  end

  assign out_valid_o      = out_vld_q;
  assign out_char_o       = out_res_q.out_char;
  assign char_valid_o     = out_res_q.char_valid;
  assign parse_status_o   = out_res_q.status;
  assign consumed_count_o = out_res_q.count;

endmodule

@@ rtl/qsu_checker.sv @@
// port-level checks for the quoted string unescaper, bound to the top level
// depends on qsu_pkg
module qsu_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic [qsu_pkg::CharW-1:0]  out_char_o,
  input logic                       char_valid_o,
  input logic [1:0]                 parse_status_o,
  input logic [qsu_pkg::CountW-1:0] consumed_count_o,
  input logic                       out_valid_o,
  input logic                       out_stall_i
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_char_o)
      && $stable(char_valid_o) && $stable(parse_status_o) && $stable(consumed_count_o))
    else $error("result beat changed while stalled");

  a_reject: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && parse_status_o == qsu_pkg::StReject |->
      consumed_count_o == '0 && !char_valid_o)
    else $error("rejected beat carries a count or a byte");

  a_char_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && char_valid_o |->
      parse_status_o == qsu_pkg::StRun || parse_status_o == qsu_pkg::StUnterm)
    else $error("decoded byte with closing or reject status");

  a_char_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !char_valid_o |-> out_char_o == qsu_pkg::ChNul)
    else $error("byte not cleared when no byte decoded");

  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> consumed_count_o <= qsu_pkg::CountCap)
    else $error("count past saturation");

endmodule

bind quoted_string_unescaper qsu_checker u_qsu_checker (.*);
